@@ hw/rtl/cws_pkg.sv @@
// Shared constants, codes, types and helpers of the congestion window sender.
package cws_pkg;

  // Ring and field sizes
  localparam int WINDOW_SLOTS  = 32;
  localparam int SEQ_BITS      = 16;
  localparam int SUM_BITS      = SEQ_BITS + 1;
  localparam int SLOT_BITS     = $clog2(WINDOW_SLOTS);
  localparam int SW            = SLOT_BITS + 1;
  localparam int CWND_BITS     = 6;
  localparam int CWND_CAP      = (WINDOW_SLOTS < 32) ? WINDOW_SLOTS : 32;
  localparam int REQ_BITS      = 2;
  localparam int KIND_BITS     = 3;
  localparam int TOTAL_BITS    = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;

  // Register and limit values
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX   = 16'hFFFE;
  localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = 16'd1;
  localparam logic [CWND_BITS-1:0]  THR_MAX     = 6'd32;
  localparam logic [CWND_BITS-1:0]  THR_RESET   = 6'd16;

  // Request codes
  localparam logic [REQ_BITS-1:0] REQ_START   = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_ACK     = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_SEGMENTS    = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_THRESHOLD = 1'b1;

  typedef enum logic [2:0] {
    ST_EMPTY        = 3'd0,
    ST_WAITING      = 3'd1,
    ST_ACKED        = 3'd2,
    ST_OUT_OF_ORDER = 3'd3,
    ST_TIMEOUT      = 3'd4
  } slot_state_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_SEND    = 3'd0,
    KIND_ACK     = 3'd1,
    KIND_SUCCESS = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_DONE    = 3'd4
  } kind_t;

  // Slot ring access from the sequencer
  typedef struct packed {
    logic                 clear_all;
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_idx;
    slot_state_t          wr_data;
    logic [SLOT_BITS-1:0] rd_idx;
  } slot_req_t;

  // Shared adder / comparator: sum = a + b, ge = (sum >= c)
  typedef struct packed {
    logic [SUM_BITS-1:0] a;
    logic [SUM_BITS-1:0] b;
    logic [SUM_BITS-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic                ge;
  } alu_rsp_t;

  typedef struct packed {
    kind_t                kind;
    logic [SEQ_BITS-1:0]  seq;
    logic                 retx;
    logic [SEQ_BITS-1:0]  base;
    logic [CWND_BITS-1:0] cwnd;
    logic [CWND_BITS-1:0] thr;
    logic                 last;
  } result_t;

  // Ring wrap of a value known to stay below twice the ring size
  function automatic logic [SLOT_BITS-1:0] slot_wrap(input logic [SW-1:0] x);
    logic [SW-1:0] y;
    y = (x >= SW'(WINDOW_SLOTS)) ? x - SW'(WINDOW_SLOTS) : x;
    return y[SLOT_BITS-1:0];
  endfunction

endpackage

@@ hw/rtl/cws_slots.sv @@
// Slot status ring: one state per sequence, single write and single read port.
module cws_slots (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cws_pkg::slot_req_t     req,
  output cws_pkg::slot_state_t   rd_data
);

  cws_pkg::slot_state_t slot_r [cws_pkg::WINDOW_SLOTS];

  // Reset and transfer begin empty the whole ring at once
  always_ff @(posedge clk) begin
    if (!rst_n || req.clear_all) begin
      for (int i = 0; i < cws_pkg::WINDOW_SLOTS; i++) begin
        slot_r[i] <= cws_pkg::ST_EMPTY;
      end
    end else if (req.wr_en) begin
      slot_r[req.wr_idx] <= req.wr_data;
    end
  end

  assign rd_data = slot_r[req.rd_idx];

endmodule

@@ hw/rtl/cws_alu.sv @@
// Shared sequence adder and comparator used by the steps of the sequencer.
module cws_alu (
  input  cws_pkg::alu_req_t req,
  output cws_pkg::alu_rsp_t rsp
);

  // One add, one compare against the bound
  always_comb begin
    rsp.sum = req.a + req.b;
    rsp.ge  = (rsp.sum >= req.c);
  end

endmodule

@@ hw/rtl/cws_ctrl.sv @@
// Sequencer: window state, round walks, ack handling and result generation.
module cws_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cws_pkg::REQ_BITS-1:0]         in_req_type,
  input  logic [cws_pkg::SEQ_BITS-1:0]         in_ack_seq,
  input  logic [cws_pkg::TOTAL_BITS-1:0]       total_segments,
  input  logic [cws_pkg::CWND_BITS-1:0]        initial_threshold,
  input  logic                                 out_free,
  output logic                                 res_valid,
  output cws_pkg::result_t                     res,
  output cws_pkg::slot_req_t                   slot_req,
  input  cws_pkg::slot_state_t                 slot_rd,
  output cws_pkg::alu_req_t                    alu_req,
  input  cws_pkg::alu_rsp_t                    alu_rsp
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DECODE = 15'b000000000000010,
    S_SCHK   = 15'b000000000000100,
    S_SLIM   = 15'b000000000001000,
    S_SEND   = 15'b000000000010000,
    S_ARNG   = 15'b000000000100000,
    S_ACHK   = 15'b000000001000000,
    S_CLR    = 15'b000000010000000,
    S_AUPD   = 15'b000000100000000,
    S_EACK   = 15'b000001000000000,
    S_ESUCC  = 15'b000010000000000,
    S_TWALK  = 15'b000100000000000,
    S_TUPD   = 15'b001000000000000,
    S_ETOUT  = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  state_t                               state_r, state_nxt;
  logic [cws_pkg::REQ_BITS-1:0]         req_r, req_nxt;
  logic [cws_pkg::SEQ_BITS-1:0]         ack_r, ack_nxt;
  logic [cws_pkg::SEQ_BITS-1:0]         base_r, base_nxt;
  logic [cws_pkg::SLOT_BITS-1:0]        base_slot_r, base_slot_nxt;
  logic [cws_pkg::CWND_BITS-1:0]        cwnd_r, cwnd_nxt;
  logic [cws_pkg::CWND_BITS-1:0]        ssthresh_r, ssthresh_nxt;
  logic [cws_pkg::CWND_BITS-1:0]        acks_r, acks_nxt;
  logic [cws_pkg::CWND_BITS-1:0]        round_len_r, round_len_nxt;
  logic                                 round_open_r, round_open_nxt;
  logic                                 xfer_r, xfer_nxt;
  logic [cws_pkg::SEQ_BITS-1:0]         cur_r, cur_nxt;
  logic [cws_pkg::SLOT_BITS-1:0]        cur_slot_r, cur_slot_nxt;
  logic [cws_pkg::SUM_BITS-1:0]         limit_r, limit_nxt;
  logic [cws_pkg::CWND_BITS-1:0]        cnt_r, cnt_nxt;
  logic                                 gap_valid_r, gap_valid_nxt;
  logic [cws_pkg::SEQ_BITS-1:0]         gap_r, gap_nxt;
  logic [cws_pkg::SLOT_BITS-1:0]        gap_slot_r, gap_slot_nxt;

  logic [cws_pkg::TOTAL_BITS-1:0]       seg_cnt;
  logic [cws_pkg::SUM_BITS-1:0]         end_seq;
  logic [cws_pkg::CWND_BITS-1:0]        thr_load;
  logic [cws_pkg::CWND_BITS:0]          cwnd_grow;
  logic [cws_pkg::CWND_BITS-1:0]        cwnd_next_round;
  logic [cws_pkg::CWND_BITS-1:0]        cwnd_half;
  logic [cws_pkg::SW-1:0]               ack_off;
  logic [cws_pkg::SLOT_BITS-1:0]        ack_slot;
  logic [cws_pkg::SLOT_BITS-1:0]        cur_slot_inc;
  logic [cws_pkg::SLOT_BITS-1:0]        base_slot_adv;
  logic [cws_pkg::CWND_BITS-1:0]        acks_inc;

  // Window arithmetic on narrow values
  always_comb begin
    if (total_segments == '0) begin
      seg_cnt = cws_pkg::TOTAL_BITS'(1);
    end else if (total_segments > cws_pkg::TOTAL_MAX) begin
      seg_cnt = cws_pkg::TOTAL_MAX;
    end else begin
      seg_cnt = total_segments;
    end
    end_seq = cws_pkg::SUM_BITS'(seg_cnt) + cws_pkg::SUM_BITS'(1);

    if (initial_threshold == '0) begin
      thr_load = cws_pkg::CWND_BITS'(1);
    end else if (initial_threshold > cws_pkg::THR_MAX) begin
      thr_load = cws_pkg::THR_MAX;
    end else begin
      thr_load = initial_threshold;
    end

    // doubling below the threshold, linear above, capped at the ring
    cwnd_grow = (cwnd_r >= ssthresh_r) ? {1'b0, cwnd_r} + 1'b1 : {cwnd_r, 1'b0};
    cwnd_next_round = (cwnd_grow > (cws_pkg::CWND_BITS + 1)'(cws_pkg::CWND_CAP)) ?
                      cws_pkg::CWND_BITS'(cws_pkg::CWND_CAP) :
                      cwnd_grow[cws_pkg::CWND_BITS-1:0];
    cwnd_half = (cwnd_r > cws_pkg::CWND_BITS'(2)) ? (cwnd_r >> 1) : cws_pkg::CWND_BITS'(1);

    // ack slot: offset from base is below the round length
    ack_off = ack_r[cws_pkg::SW-1:0] - base_r[cws_pkg::SW-1:0];
    ack_slot = cws_pkg::slot_wrap(cws_pkg::SW'(base_slot_r) + ack_off);
    cur_slot_inc = cws_pkg::slot_wrap(cws_pkg::SW'(cur_slot_r) + cws_pkg::SW'(1));
    base_slot_adv = cws_pkg::slot_wrap(cws_pkg::SW'(base_slot_r) + cws_pkg::SW'(round_len_r));
    acks_inc = acks_r + 1'b1;
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    ack_nxt        = ack_r;
    base_nxt       = base_r;
    base_slot_nxt  = base_slot_r;
    cwnd_nxt       = cwnd_r;
    ssthresh_nxt   = ssthresh_r;
    acks_nxt       = acks_r;
    round_len_nxt  = round_len_r;
    round_open_nxt = round_open_r;
    xfer_nxt       = xfer_r;
    cur_nxt        = cur_r;
    cur_slot_nxt   = cur_slot_r;
    limit_nxt      = limit_r;
    cnt_nxt        = cnt_r;
    gap_valid_nxt  = gap_valid_r;
    gap_nxt        = gap_r;
    gap_slot_nxt   = gap_slot_r;

    in_ready  = 1'b0;
    res_valid = 1'b0;
    res.kind  = cws_pkg::KIND_SEND;
    res.seq   = '0;
    res.retx  = 1'b0;
    res.base  = base_r;
    res.cwnd  = cwnd_r;
    res.thr   = ssthresh_r;
    res.last  = 1'b0;

    slot_req.clear_all = 1'b0;
    slot_req.wr_en     = 1'b0;
    slot_req.wr_idx    = cur_slot_r;
    slot_req.wr_data   = cws_pkg::ST_EMPTY;
    slot_req.rd_idx    = cur_slot_r;

    // default operation: base >= end of transfer
    alu_req.a = cws_pkg::SUM_BITS'(base_r);
    alu_req.b = '0;
    alu_req.c = end_seq;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_req_type;
          ack_nxt   = in_ack_seq;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (req_r)
          cws_pkg::REQ_START: begin
            if (round_open_r) begin
              state_nxt = S_IDLE;
            end else begin
              if (!xfer_r) begin
                slot_req.clear_all = 1'b1;
                base_nxt      = cws_pkg::SEQ_BITS'(1);
                base_slot_nxt = cws_pkg::SLOT_BITS'(1);
                cwnd_nxt      = cws_pkg::CWND_BITS'(1);
                ssthresh_nxt  = thr_load;
                acks_nxt      = '0;
                xfer_nxt      = 1'b1;
              end
              state_nxt = S_SCHK;
            end
          end
          cws_pkg::REQ_ACK: begin
            // ack >= base
            alu_req.a = cws_pkg::SUM_BITS'(ack_r);
            alu_req.c = cws_pkg::SUM_BITS'(base_r);
            state_nxt = (round_open_r && alu_rsp.ge) ? S_ARNG : S_IDLE;
          end
          cws_pkg::REQ_TIMEOUT: begin
            alu_req.b = cws_pkg::SUM_BITS'(round_len_r);
            if (round_open_r) begin
              limit_nxt     = alu_rsp.sum;
              cur_nxt       = base_r;
              cur_slot_nxt  = base_slot_r;
              gap_valid_nxt = 1'b0;
              state_nxt     = S_TWALK;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SCHK: begin
        state_nxt = alu_rsp.ge ? S_DONE : S_SLIM;
      end

      S_SLIM: begin
        // round ends at the smaller of base + cwnd and the transfer end
        alu_req.b    = cws_pkg::SUM_BITS'(cwnd_r);
        limit_nxt    = alu_rsp.ge ? end_seq : alu_rsp.sum;
        cur_nxt      = base_r;
        cur_slot_nxt = base_slot_r;
        cnt_nxt      = '0;
        state_nxt    = S_SEND;
      end

      S_SEND: begin
        alu_req.a = cws_pkg::SUM_BITS'(cur_r);
        alu_req.b = cws_pkg::SUM_BITS'(1);
        alu_req.c = limit_r;
        res_valid = 1'b1;
        res.kind  = cws_pkg::KIND_SEND;
        res.seq   = cur_r;
        res.retx  = (slot_rd != cws_pkg::ST_EMPTY);
        res.last  = alu_rsp.ge;
        if (out_free) begin
          slot_req.wr_en   = 1'b1;
          slot_req.wr_data = cws_pkg::ST_WAITING;
          cur_nxt      = alu_rsp.sum[cws_pkg::SEQ_BITS-1:0];
          cur_slot_nxt = cur_slot_inc;
          cnt_nxt      = cnt_r + 1'b1;
          if (alu_rsp.ge) begin
            round_len_nxt  = cnt_r + 1'b1;
            acks_nxt       = '0;
            round_open_nxt = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end

      S_ARNG: begin
        // ack < base + round length
        alu_req.b = cws_pkg::SUM_BITS'(round_len_r);
        alu_req.c = cws_pkg::SUM_BITS'(ack_r) + cws_pkg::SUM_BITS'(1);
        if (alu_rsp.ge) begin
          limit_nxt    = alu_rsp.sum;
          cur_nxt      = base_r;
          cur_slot_nxt = base_slot_r;
          state_nxt    = S_ACHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_ACHK: begin
        slot_req.rd_idx = ack_slot;
        slot_req.wr_idx = ack_slot;
        if (slot_rd == cws_pkg::ST_WAITING) begin
          slot_req.wr_en   = 1'b1;
          slot_req.wr_data = cws_pkg::ST_ACKED;
          acks_nxt         = acks_inc;
          state_nxt        = (acks_inc == round_len_r) ? S_CLR : S_EACK;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_CLR: begin
        // empty the slots of the finished round
        alu_req.a = cws_pkg::SUM_BITS'(cur_r);
        alu_req.b = cws_pkg::SUM_BITS'(1);
        alu_req.c = limit_r;
        slot_req.wr_en   = 1'b1;
        slot_req.wr_data = cws_pkg::ST_EMPTY;
        cur_nxt      = alu_rsp.sum[cws_pkg::SEQ_BITS-1:0];
        cur_slot_nxt = cur_slot_inc;
        if (alu_rsp.ge) begin
          state_nxt = S_AUPD;
        end
      end

      S_AUPD: begin
        alu_req.b      = cws_pkg::SUM_BITS'(round_len_r);
        base_nxt       = alu_rsp.sum[cws_pkg::SEQ_BITS-1:0];
        base_slot_nxt  = base_slot_adv;
        cwnd_nxt       = cwnd_next_round;
        round_open_nxt = 1'b0;
        acks_nxt       = '0;
        state_nxt      = S_EACK;
      end

      S_EACK: begin
        res_valid = 1'b1;
        res.kind  = cws_pkg::KIND_ACK;
        res.seq   = ack_r;
        res.last  = round_open_r;
        if (out_free) begin
          state_nxt = round_open_r ? S_IDLE : S_ESUCC;
        end
      end

      S_ESUCC: begin
        res_valid = 1'b1;
        res.kind  = cws_pkg::KIND_SUCCESS;
        res.last  = !alu_rsp.ge;
        if (out_free) begin
          state_nxt = alu_rsp.ge ? S_DONE : S_IDLE;
        end
      end

      S_TWALK: begin
        // mark waiting slots timed out, note the first gap; acked slots past it go out of order, others empty
        alu_req.a = cws_pkg::SUM_BITS'(cur_r);
        alu_req.b = cws_pkg::SUM_BITS'(1);
        alu_req.c = limit_r;
        if (slot_rd == cws_pkg::ST_WAITING) begin
          slot_req.wr_en   = 1'b1;
          slot_req.wr_data = cws_pkg::ST_TIMEOUT;
          if (!gap_valid_r) begin
            gap_valid_nxt = 1'b1;
            gap_nxt       = cur_r;
            gap_slot_nxt  = cur_slot_r;
          end
        end else if (slot_rd == cws_pkg::ST_ACKED) begin
          slot_req.wr_en   = 1'b1;
          slot_req.wr_data = gap_valid_r ? cws_pkg::ST_OUT_OF_ORDER : cws_pkg::ST_EMPTY;
        end
        cur_nxt      = alu_rsp.sum[cws_pkg::SEQ_BITS-1:0];
        cur_slot_nxt = cur_slot_inc;
        if (alu_rsp.ge) begin
          state_nxt = S_TUPD;
        end
      end

      S_TUPD: begin
        alu_req.b      = cws_pkg::SUM_BITS'(round_len_r);
        base_nxt       = gap_valid_r ? gap_r : alu_rsp.sum[cws_pkg::SEQ_BITS-1:0];
        base_slot_nxt  = gap_valid_r ? gap_slot_r : base_slot_adv;
        ssthresh_nxt   = cwnd_half;
        cwnd_nxt       = cws_pkg::CWND_BITS'(1);
        round_open_nxt = 1'b0;
        acks_nxt       = '0;
        state_nxt      = S_ETOUT;
      end

      S_ETOUT: begin
        res_valid = 1'b1;
        res.kind  = cws_pkg::KIND_TIMEOUT;
        res.last  = !alu_rsp.ge;
        if (out_free) begin
          state_nxt = alu_rsp.ge ? S_DONE : S_IDLE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        res.kind  = cws_pkg::KIND_DONE;
        res.last  = 1'b1;
        if (out_free) begin
          xfer_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_r       <= cws_pkg::SEQ_BITS'(1);
      base_slot_r  <= cws_pkg::SLOT_BITS'(1);
      cwnd_r       <= cws_pkg::CWND_BITS'(1);
      ssthresh_r   <= cws_pkg::THR_RESET;
      acks_r       <= '0;
      round_len_r  <= '0;
      round_open_r <= 1'b0;
      xfer_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_r       <= base_nxt;
      base_slot_r  <= base_slot_nxt;
      cwnd_r       <= cwnd_nxt;
      ssthresh_r   <= ssthresh_nxt;
      acks_r       <= acks_nxt;
      round_len_r  <= round_len_nxt;
      round_open_r <= round_open_nxt;
      xfer_r       <= xfer_nxt;
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    ack_r       <= ack_nxt;
    cur_r       <= cur_nxt;
    cur_slot_r  <= cur_slot_nxt;
    limit_r     <= limit_nxt;
    cnt_r       <= cnt_nxt;
    gap_valid_r <= gap_valid_nxt;
    gap_r       <= gap_nxt;
    gap_slot_r  <= gap_slot_nxt;
  end

  // An open round always belongs to a running transfer
  a_open_in_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    round_open_r |-> xfer_r)
    else $error("round open without an active transfer");

  // Open round: non-empty, within the ring, acks never beyond its length
  a_round_len: assert property (@(posedge clk) disable iff (!rst_n)
    round_open_r |-> (round_len_r != '0 &&
                      round_len_r <= cws_pkg::CWND_BITS'(cws_pkg::CWND_CAP) &&
                      acks_r <= round_len_r))
    else $error("round length or ack count out of range");

  // Window and threshold stay in their legal ranges
  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cwnd_r != '0 && cwnd_r <= cws_pkg::CWND_BITS'(cws_pkg::CWND_CAP) &&
     ssthresh_r != '0 && ssthresh_r <= cws_pkg::THR_MAX))
    else $error("cwnd or ssthresh out of range");

  // A round start that sends its final command opens the round
  a_send_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND && out_free && alu_rsp.ge) |=> (round_open_r && state_r == S_IDLE))
    else $error("round not opened after last send");

endmodule

@@ hw/rtl/congestion_window_sender.sv @@
// Top level of the congestion window sender: config registers, sequencer, ring, output register.
// Round start: decode, start check and window limit states, then one send command per cycle while
// the output register is free. Ack: decode, range check and slot check; an ack completing the round
// first clears round_len slots, one a cycle, then updates base and window before its result.
// Timeout: walks round_len slots one a cycle, then updates the window before its timeout result.
// One item at a time through the shared adder; next beat taken once the last
// result is registered.
// Reset (rst_n low, synchronous) empties the whole slot ring in that cycle and loads base 1, cwnd 1.
module congestion_window_sender (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cws_pkg::REQ_BITS-1:0]        in_req_type,
  input  logic [cws_pkg::SEQ_BITS-1:0]        in_ack_seq,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cws_pkg::KIND_BITS-1:0]       out_result_kind,
  output logic [cws_pkg::SEQ_BITS-1:0]        out_seq,
  output logic                                out_is_retransmit,
  output logic [cws_pkg::SEQ_BITS-1:0]        out_window_base,
  output logic [cws_pkg::CWND_BITS-1:0]       out_window_size,
  output logic [cws_pkg::CWND_BITS-1:0]       out_threshold,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cws_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [cws_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic [cws_pkg::TOTAL_BITS-1:0] total_segments_r;
  logic [cws_pkg::CWND_BITS-1:0]  initial_threshold_r;
  logic                           out_valid_r;
  cws_pkg::result_t               out_res_r;
  logic                           out_free;
  logic                           res_valid;
  cws_pkg::result_t               res;
  cws_pkg::slot_req_t             slot_req;
  cws_pkg::slot_state_t           slot_rd;
  cws_pkg::alu_req_t              alu_req;
  cws_pkg::alu_rsp_t              alu_rsp;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_segments_r    <= cws_pkg::TOTAL_RESET;
      initial_threshold_r <= cws_pkg::THR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cws_pkg::CFG_TOTAL_SEGMENTS: begin
          total_segments_r <= cfg_data[cws_pkg::TOTAL_BITS-1:0];
        end
        cws_pkg::CFG_INITIAL_THRESHOLD: begin
          initial_threshold_r <= cfg_data[cws_pkg::CWND_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  cws_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_ack_seq        (in_ack_seq),
    .total_segments    (total_segments_r),
    .initial_threshold (initial_threshold_r),
    .out_free          (out_free),
    .res_valid         (res_valid),
    .res               (res),
    .slot_req          (slot_req),
    .slot_rd           (slot_rd),
    .alu_req           (alu_req),
    .alu_rsp           (alu_rsp)
  );

  cws_slots u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (slot_req),
    .rd_data (slot_rd)
  );

  cws_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Output register: refilled in the cycle its beat is taken
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_res_r.kind;
  assign out_seq           = out_res_r.seq;
  assign out_is_retransmit = out_res_r.retx;
  assign out_window_base   = out_res_r.base;
  assign out_window_size   = out_res_r.cwnd;
  assign out_threshold     = out_res_r.thr;
  assign out_last          = out_res_r.last;

endmodule

@@ bench/cws_window_check.sv @@
// Window predictor and result beat comparison for the congestion window sender bench.
`timescale 1ns / 100ps
module cws_window_check
  import cws_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [REQ_BITS-1:0]      in_req_type,
  input  logic [SEQ_BITS-1:0]      in_ack_seq,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [KIND_BITS-1:0]     out_result_kind,
  input  logic [SEQ_BITS-1:0]      out_seq,
  input  logic                     out_is_retransmit,
  input  logic [SEQ_BITS-1:0]      out_window_base,
  input  logic [CWND_BITS-1:0]     out_window_size,
  input  logic [CWND_BITS-1:0]     out_threshold,
  input  logic                     out_last,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       mismatches,
  output int                       owed_count,
  output logic                     round_live,
  output int unsigned              round_base,
  output int unsigned              round_len,
  output int                       beats_checked,
  output int                       transfers_done,
  output int                       round_timeouts
);

  // Shadow of the sender: slot ring, window and registers
  slot_state_t            ring [WINDOW_SLOTS];
  int unsigned            cwnd_now;
  int unsigned            thr_now;
  int unsigned            acks_now;
  logic                   xfer_live;
  logic [TOTAL_BITS-1:0]  total_reg;
  logic [CWND_BITS-1:0]   thr_reg;

  // Results the block still owes, oldest first
  result_t                owed [$];
  result_t                due;

  // One past the last segment, with the count clamped to its legal range
  function automatic int unsigned stop_seq();
    int unsigned t;
    t = 32'(total_reg);
    if (t == 0) t = 1;
    if (t > TOTAL_MAX) t = 32'(TOTAL_MAX);
    return t + 1;
  endfunction

  task automatic emit(input kind_t kind, input int unsigned seq, input logic retx);
    result_t r;
    r.kind = kind;
    r.seq  = seq[SEQ_BITS-1:0];
    r.retx = retx;
    r.base = round_base[SEQ_BITS-1:0];
    r.cwnd = cwnd_now[CWND_BITS-1:0];
    r.thr  = thr_now[CWND_BITS-1:0];
    r.last = 1'b0;
    owed.push_back(r);
  endtask

  // Transfer ends once base has passed the last segment
  task automatic close_if_finished();
    if (round_base >= stop_seq()) begin
      xfer_live = 1'b0;
      emit(KIND_DONE, 0, 1'b0);
      transfers_done++;
    end
  endtask

  // Advance the shadow by one accepted request beat
  task automatic step_sender(input logic [REQ_BITS-1:0] req, input logic [SEQ_BITS-1:0] ack);
    int unsigned lim, i, gap, grown;
    int          owed_at_entry;
    result_t     r;
    owed_at_entry = owed.size();
    case (req)
      REQ_START: begin
        if (!round_live) begin
          // transfer begin: fresh ring and the configured threshold
          if (!xfer_live) begin
            foreach (ring[k]) ring[k] = ST_EMPTY;
            round_base = 1;
            cwnd_now   = 1;
            if (thr_reg == 0) thr_now = 1;
            else if (thr_reg > THR_MAX) thr_now = 32'(THR_MAX);
            else thr_now = 32'(thr_reg);
            acks_now  = 0;
            xfer_live = 1'b1;
          end
          lim = stop_seq();
          if (round_base >= lim) begin
            close_if_finished();
          end else begin
            round_len = 0;
            for (i = round_base; i < round_base + cwnd_now && i < lim; i++) begin
              emit(KIND_SEND, i, ring[i % WINDOW_SLOTS] != ST_EMPTY);
              ring[i % WINDOW_SLOTS] = ST_WAITING;
              round_len++;
            end
            acks_now   = 0;
            round_live = 1'b1;
          end
        end
      end
      REQ_ACK: begin
        if (round_live && ack >= round_base && ack < round_base + round_len &&
            ring[ack % WINDOW_SLOTS] == ST_WAITING) begin
          ring[ack % WINDOW_SLOTS] = ST_ACKED;
          acks_now = (acks_now + 1) & 32'hFFFF;
          if (acks_now != round_len) begin
            emit(KIND_ACK, ack, 1'b0);
          end else begin
            // round complete: free its slots, move base, grow the window
            for (i = 0; i < round_len; i++) ring[(round_base + i) % WINDOW_SLOTS] = ST_EMPTY;
            round_base += round_len;
            grown    = (cwnd_now >= thr_now) ? cwnd_now + 1 : cwnd_now * 2;
            cwnd_now = (grown > CWND_CAP) ? CWND_CAP : grown;
            round_live = 1'b0;
            acks_now   = 0;
            emit(KIND_ACK, ack, 1'b0);
            emit(KIND_SUCCESS, 0, 1'b0);
            close_if_finished();
          end
        end
      end
      REQ_TIMEOUT: begin
        if (round_live) begin
          // waiting slots time out; acks past the first gap stay as out of order
          gap = 0;
          for (i = round_base; i < round_base + round_len; i++) begin
            if (ring[i % WINDOW_SLOTS] == ST_WAITING) begin
              ring[i % WINDOW_SLOTS] = ST_TIMEOUT;
              if (gap == 0) gap = i;
            end else if (ring[i % WINDOW_SLOTS] == ST_ACKED) begin
              ring[i % WINDOW_SLOTS] = (gap == 0) ? ST_EMPTY : ST_OUT_OF_ORDER;
            end
          end
          round_base = (gap != 0) ? gap : round_base + round_len;
          thr_now    = (cwnd_now > 2) ? cwnd_now / 2 : 1;
          cwnd_now   = 1;
          round_live = 1'b0;
          acks_now   = 0;
          round_timeouts++;
          emit(KIND_TIMEOUT, 0, 1'b0);
          close_if_finished();
        end
      end
      default: ;
    endcase
    // flag the final result of this beat
    if (owed.size() > owed_at_entry) begin
      r = owed.pop_back();
      r.last = 1'b1;
      owed.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (ring[k]) ring[k] = ST_EMPTY;
      round_base     = 1;
      round_len      = 0;
      round_live     = 1'b0;
      cwnd_now       = 1;
      thr_now        = 32'(THR_RESET);
      acks_now       = 0;
      xfer_live      = 1'b0;
      total_reg      = TOTAL_RESET;
      thr_reg        = THR_RESET;
      mismatches     = 0;
      beats_checked  = 0;
      transfers_done = 0;
      round_timeouts = 0;
      owed.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TOTAL_SEGMENTS) total_reg = cfg_data[TOTAL_BITS-1:0];
        else if (cfg_index == CFG_INITIAL_THRESHOLD) thr_reg = cfg_data[CWND_BITS-1:0];
      end
      // result beats against the oldest owed result
      if (out_valid && out_ready) begin
        beats_checked++;
        if (owed.size() == 0) begin
          $error("result beat with nothing owed: kind %0d seq %0d", out_result_kind, out_seq);
          mismatches++;
        end else begin
          due = owed.pop_front();
          check_field("result_kind", 32'(due.kind), 32'(out_result_kind));
          check_field("seq", 32'(due.seq), 32'(out_seq));
          check_field("is_retransmit", 32'(due.retx), 32'(out_is_retransmit));
          check_field("window_base", 32'(due.base), 32'(out_window_base));
          check_field("window_size", 32'(due.cwnd), 32'(out_window_size));
          check_field("threshold", 32'(due.thr), 32'(out_threshold));
          check_field("last", 32'(due.last), 32'(out_last));
        end
      end
      if (in_valid && in_ready) step_sender(in_req_type, in_ack_seq);
    end
    owed_count = owed.size();
  end

endmodule

@@ bench/congestion_window_sender_tb.sv @@
// Top of the congestion window sender bench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 100ps
module congestion_window_sender_tb;
  import cws_pkg::*;

  localparam logic [REQ_BITS-1:0] REQ_UNDEF = 2'd3;
  localparam int LIMIT           = 300000;
  localparam int DRAIN           = 80;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 40;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [REQ_BITS-1:0]      in_req_type = REQ_START;
  logic [SEQ_BITS-1:0]      in_ack_seq = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [KIND_BITS-1:0]     out_result_kind;
  logic [SEQ_BITS-1:0]      out_seq;
  logic                     out_is_retransmit;
  logic [SEQ_BITS-1:0]      out_window_base;
  logic [CWND_BITS-1:0]     out_window_size;
  logic [CWND_BITS-1:0]     out_threshold;
  logic                     out_last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_TOTAL_SEGMENTS;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  int          mismatches;
  int          owed_count;
  logic        round_live;
  int unsigned round_base;
  int unsigned round_len;
  int          beats_checked;
  int          transfers_done;
  int          round_timeouts;

  int tx_idle = 30;
  int rx_idle = 53;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int reqs_sent = 0;
  int items_done = 0;
  int cycles;

  congestion_window_sender dut (.*);
  cws_window_check chk (.*);

  always #10 clk = ~clk;

  // Cycle limit
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Cycle limit reached with %0d results still owed", owed_count);
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random ready, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Offer one request beat; returns at the falling edge after it was taken
  task automatic put_req(input logic [REQ_BITS-1:0] req, input logic [SEQ_BITS-1:0] seq);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_ack_seq  <= seq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reqs_sent++;
    @(negedge clk);
  endtask

  // Stop offering until every owed result is back, then let extra cycles pass
  task automatic drain_owed(input int extra);
    in_valid <= 1'b0;
    @(negedge clk);
    while (owed_count != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    drain_owed(DRAIN);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Noise beats, mostly ones the block drops: stray, stale, beyond the window, undefined, repeated
  task automatic make_noise(input int unsigned acked);
    case ($urandom_range(5))
      0: put_req(REQ_ACK, SEQ_BITS'($urandom));
      1: put_req(REQ_ACK, SEQ_BITS'(round_base - 1));
      2: put_req(REQ_ACK, SEQ_BITS'(round_base + round_len));
      3: put_req(REQ_UNDEF, SEQ_BITS'($urandom));
      4: put_req(REQ_START, SEQ_BITS'($urandom));
      default: begin
        if (round_live) put_req(REQ_ACK, SEQ_BITS'(acked));
        else put_req(REQ_TIMEOUT, SEQ_BITS'($urandom));
      end
    endcase
  endtask

  // One round: start, acks in shuffled order, sometimes cut short by a timeout
  task automatic play_round();
    int unsigned order [$];
    int unsigned tmp, acked;
    int          j, k, cut;
    bit          cut_short;
    put_req(REQ_START, SEQ_BITS'($urandom));
    items_done++;
    if (!round_live) return;
    for (j = 0; j < round_len; j++) order.push_back(round_base + j);
    for (j = order.size() - 1; j > 0; j--) begin
      k = $urandom_range(j);
      tmp = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    cut_short = ($urandom_range(99) < 20);
    cut = cut_short ? $urandom_range(order.size() - 1) : order.size();
    acked = 0;
    for (j = 0; j < cut; j++) begin
      if ($urandom_range(99) < 10) make_noise(acked);
      put_req(REQ_ACK, SEQ_BITS'(order[j]));
      items_done++;
      acked = order[j];
    end
    if (cut_short) begin
      put_req(REQ_TIMEOUT, SEQ_BITS'($urandom));
      items_done++;
    end
  endtask

  initial begin : stimulus
    int ph, quota;
    bit paused;
    logic [TOTAL_BITS-1:0]    seg_count;
    logic [CFG_DATA_BITS-1:0] thr_word;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset registers, one segment per transfer
    put_req(REQ_ACK, 16'd1);          // no round open
    put_req(REQ_TIMEOUT, 16'd0);      // no round open
    put_req(REQ_START, 16'd0);        // transfer begin
    put_req(REQ_START, 16'd0);        // round already open
    put_req(REQ_ACK, 16'd0);          // below the window
    put_req(REQ_ACK, 16'hFFFF);       // beyond the window
    put_req(REQ_ACK, 16'd1);          // closes round and transfer
    put_req(REQ_START, 16'hFFFF);
    put_req(REQ_TIMEOUT, 16'hFFFF);   // threshold floor
    put_req(REQ_START, 16'd0);        // retransmit after timeout
    put_req(REQ_UNDEF, 16'hFFFF);
    put_req(REQ_ACK, 16'd1);
    // Out of range registers: zero segments, zero threshold
    write_reg(CFG_TOTAL_SEGMENTS, 16'd0);
    write_reg(CFG_INITIAL_THRESHOLD, 16'hFFC0);
    put_req(REQ_START, 16'd0);
    put_req(REQ_ACK, 16'd1);
    // Largest counts, threshold above range; out of order ack then timeout
    write_reg(CFG_TOTAL_SEGMENTS, 16'hFFFF);
    write_reg(CFG_INITIAL_THRESHOLD, 16'd63);
    put_req(REQ_START, 16'd0);
    put_req(REQ_ACK, 16'd1);
    put_req(REQ_START, 16'd0);
    put_req(REQ_ACK, 16'd3);
    put_req(REQ_ACK, 16'd3);          // repeated ack
    put_req(REQ_TIMEOUT, 16'd0);
    put_req(REQ_START, 16'd0);
    put_req(REQ_ACK, 16'd2);
    put_req(REQ_START, 16'd0);
    put_req(REQ_ACK, 16'd4);
    put_req(REQ_ACK, 16'd3);
    items_done = 25;

    // Random rounds over six register settings and three idling patterns
    paused = 1'b0;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          seg_count = TOTAL_BITS'($urandom_range(40, 1));
          thr_word  = CFG_DATA_BITS'($urandom);
        end
        1: begin seg_count = TOTAL_MAX;              thr_word = 16'd1; end
        2: begin seg_count = TOTAL_BITS'($urandom_range(150, 2)); thr_word = 16'd32; end
        3: begin
          seg_count = TOTAL_BITS'($urandom_range(16, 1));
          thr_word  = CFG_DATA_BITS'($urandom_range(8, 1));
        end
        4: begin seg_count = 16'd1; thr_word = CFG_DATA_BITS'($urandom_range(63, 0)); end
        default: begin
          seg_count = TOTAL_BITS'($urandom_range(300, 1));
          thr_word  = {SEQ_BITS'($urandom)} & 16'hFFC0 | 16'($urandom_range(32, 1));
        end
      endcase
      write_reg(CFG_TOTAL_SEGMENTS, seg_count);
      write_reg(CFG_INITIAL_THRESHOLD, thr_word);
      tx_idle = (ph < 2) ? 30 : (ph < 4) ? 53 : 0;
      rx_idle = (ph < 2) ? 53 : (ph < 4) ? 30 : 0;
      // long result stall while requests keep coming
      if (ph == 4) hold_req = 1'b1;
      quota = items_done + ITEMS_PER_PHASE;
      while (items_done < quota) begin
        play_round();
        if ($urandom_range(99) < 10) make_noise(0);
        // sender pause until the block has caught up
        if (ph == 1 && !paused && items_done > quota - ITEMS_PER_PHASE / 2) begin
          drain_owed(0);
          paused = 1'b1;
        end
      end
    end

    drain_owed(DRAIN);
    $display("Covered %0d request beats (%0d window steps) over the reset registers and",
             reqs_sent, items_done);
    $display("eight written settings, checking %0d result beats: %0d transfers completed,",
             beats_checked, transfers_done);
    $display("%0d round timeouts.", round_timeouts);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cws_pkg.sv
hw/rtl/cws_slots.sv
hw/rtl/cws_alu.sv
hw/rtl/cws_ctrl.sv
hw/rtl/congestion_window_sender.sv
bench/cws_window_check.sv
bench/congestion_window_sender_tb.sv
